// ===== design/cft_pkg.sv =====
// Shared types and constants for the CSV field tokenizer.
// No dependencies; every other design file imports this package.
`default_nettype none

package cft_pkg;

  // Characters the tokenizer reacts to
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Event kinds
  localparam logic [1:0] EV_CONTENT = 2'd0;
  localparam logic [1:0] EV_FIELD   = 2'd1;
  localparam logic [1:0] EV_ROW     = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  out_char;
    logic [7:0]  column;
    logic [15:0] row;
    logic        is_header;
    logic        overflow;
  } out_beat_t;

  // Status of the event queue: full to the front end, valid to the output stage
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

// ===== design/cft_front.sv =====
// Front end: accepts text bytes, classifies them and keeps the parse state.
// Depends on cft_pkg. Pushes one event per producing byte into the queue.
`default_nettype none

module cft_front #(
  parameter int MAX_COLS = 256,
  parameter int ROW_BITS = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              has_headers_i,
  input  wire              in_valid_i,
  input  cft_pkg::in_beat_t in_beat_i,
  input  wire              q_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output cft_pkg::out_beat_t push_beat_o
);
  import cft_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int CWX = (CW > 8) ? CW : 8;
  localparam int RWX = (ROW_BITS > 16) ? ROW_BITS : 16;
  localparam logic [CW-1:0]       ColMax = CW'(MAX_COLS - 1);
  localparam logic [ROW_BITS-1:0] RowMax = '1;

  logic                quoted_q, quoted_d;
  logic                pend_q, pend_d;
  logic [CW-1:0]       col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic                hdr_done_q, hdr_done_d;
  logic                ovf_q, ovf_d;

  logic                accept;
  logic                hdr;
  logic [7:0]          c;
  logic [CWX-1:0]      col_ext;
  logic [RWX-1:0]      row_ext;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign c          = in_beat_i.text_byte;
  assign hdr        = has_headers_i && !hdr_done_q;
  assign col_ext    = CWX'(col_q);
  assign row_ext    = RWX'(row_q);

  always_comb begin
    logic handled;
    logic quoted_v;
    logic ev;
    logic [1:0] kind;
    logic [7:0] ch;
    handled    = 1'b0;
    quoted_v   = quoted_q;
    ev         = 1'b0;
    kind       = EV_CONTENT;
    ch         = 8'h00;
    pend_d     = pend_q;
    col_d      = col_q;
    row_d      = row_q;
    hdr_done_d = hdr_done_q;
    ovf_d      = ovf_q;

    // A held quote resolves against this byte: doubled quote or close
    if (pend_q) begin
      pend_d = 1'b0;
      if (c == CH_QUOTE) begin
        ev      = 1'b1;
        ch      = c;
        handled = 1'b1;
      end else begin
        quoted_v = 1'b0;
      end
    end

    if (!handled) begin
      if (c == CH_QUOTE) begin
        if (quoted_v) pend_d = 1'b1;
        else          quoted_v = 1'b1;
      end else if (quoted_v) begin
        ev = 1'b1;
        ch = c;
      end else if (c == CH_COMMA) begin
        ev   = 1'b1;
        kind = EV_FIELD;
        if (col_q >= ColMax) ovf_d = 1'b1;
        else                 col_d = col_q + 1'b1;
      end else if (c == CH_LF) begin
        ev    = 1'b1;
        kind  = EV_ROW;
        col_d = '0;
        if (hdr) begin
          hdr_done_d = 1'b1;
        end else if (row_q == RowMax) begin
          ovf_d = 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else if (c != CH_CR) begin
        ev = 1'b1;
        ch = c;
      end
    end

    quoted_d = quoted_v;

    push_o                  = accept && ev;
    push_beat_o.event_kind  = kind;
    push_beat_o.out_char    = ch;
    push_beat_o.column      = col_ext[7:0];
    push_beat_o.row         = hdr ? 16'h0000 : row_ext[15:0];
    push_beat_o.is_header   = hdr;
    push_beat_o.overflow    = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q   <= 1'b0;
      pend_q     <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      hdr_done_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (accept) begin
      if (in_beat_i.end_of_text) begin
        quoted_q   <= 1'b0;
        pend_q     <= 1'b0;
        col_q      <= '0;
        row_q      <= '0;
        hdr_done_q <= 1'b0;
        ovf_q      <= 1'b0;
      end else begin
        quoted_q   <= quoted_d;
        pend_q     <= pend_d;
        col_q      <= col_d;
        row_q      <= row_d;
        hdr_done_q <= hdr_done_d;
        ovf_q      <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/cft_queue.sv =====
// Two-entry event queue between the front end and the output stage.
// Depends on cft_pkg for the event beat type.
`default_nettype none

module cft_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  cft_pkg::out_beat_t push_beat_i,
  input  wire                pop_i,
  output cft_pkg::q_status_t status_o,
  output cft_pkg::out_beat_t head_o
);
  import cft_pkg::*;

  localparam int Depth = 2;

  out_beat_t   mem_q [Depth];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_pop;

  assign status_o.valid = (cnt_q != 2'd0);
  assign status_o.full  = (cnt_q == 2'(Depth));
  assign head_o         = mem_q[rd_ptr_q];
  assign do_pop         = pop_i && status_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_beat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/cft_back.sv =====
// Back end: output register that drains the event queue onto the result port.
// Depends on cft_pkg for the event beat and queue status types.
`default_nettype none

module cft_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cft_pkg::q_status_t q_status_i,
  input  cft_pkg::out_beat_t q_head_i,
  output logic               pop_o,
  input  wire                out_stall_i,
  output logic               out_valid_o,
  output cft_pkg::out_beat_t out_beat_o
);
  import cft_pkg::*;

  logic      valid_q, valid_d;
  out_beat_t beat_q;
  logic      take;

  // Register is free when empty or its beat leaves this cycle
  assign take        = !valid_q || !out_stall_i;
  assign pop_o       = take && q_status_i.valid;
  assign valid_d     = take ? q_status_i.valid : valid_q;
  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) beat_q <= q_head_i;
  end

endmodule

`default_nettype wire

// ===== design/csv_field_tokenizer_unit.sv =====
// Top level of the CSV field tokenizer: front end, event queue, output stage.
// Depends on cft_pkg, cft_front, cft_queue and cft_back.
`default_nettype none

// CSV field tokenizer. Takes one text byte per beat and gives at most one
// event beat per text byte: a content byte with its column and row, a field
// end on an unquoted comma, or a row end on an unquoted newline. Quotes and
// unquoted carriage returns give no event of their own; a doubled quote in a
// quoted field gives one content event for the literal quote. Throughput is
// one byte per clock; the parse state (quote flags, column and row counters)
// is updated once per byte, so nothing limits the input rate except output
// backpressure. A taken byte writes its event into the two-entry event queue;
// the event moves into the output register once that register is free, and
// from there it is shown on the result port until it is accepted.
// in_stall_o rises only when the queue holds two events, so a stalled result
// port lets two more producing bytes in.
// has_headers is written through cfg_we_i/cfg_wdata_i and may only change
// while no text is in flight. end_of_text on a byte returns the parse state
// to reset once that byte is handled.

module csv_field_tokenizer_unit #(
  parameter int MAX_COLS = 256,
  parameter int ROW_BITS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // configuration
  input  wire                cfg_we_i,
  input  wire                cfg_wdata_i,
  // text input channel
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  cft_pkg::in_beat_t  in_beat_i,
  // event output channel
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output cft_pkg::out_beat_t out_beat_o
);
  import cft_pkg::*;

  logic       has_headers_q;
  logic       push;
  out_beat_t  push_beat;
  logic       pop;
  q_status_t  q_status;
  out_beat_t  q_head;

  // has_headers register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       has_headers_q <= 1'b0;
    else if (cfg_we_i) has_headers_q <= cfg_wdata_i;
  end

  // Front: classify each byte, update quote/counter state, emit an event
  cft_front #(
    .MAX_COLS (MAX_COLS),
    .ROW_BITS (ROW_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .has_headers_i (has_headers_q),
    .in_valid_i    (in_valid_i),
    .in_beat_i     (in_beat_i),
    .q_full_i      (q_status.full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .push_beat_o   (push_beat)
  );

  // Queue decouples parsing from result backpressure
  cft_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_beat_i (push_beat),
    .pop_i       (pop),
    .status_o    (q_status),
    .head_o      (q_head)
  );

  // Back: output register on the result channel
  cft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== design/cft_checker.sv =====
// Port-level checker for the CSV field tokenizer, bound to the top level.
// Depends on cft_pkg and csv_field_tokenizer_unit.
`default_nettype none

module cft_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input cft_pkg::in_beat_t  in_beat_i,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input cft_pkg::out_beat_t out_beat_o
);
  import cft_pkg::*;

  // A stalled text beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_beat_i))
    else $error("text beat changed while stalled");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed while stalled");

  // Only the three event kinds are ever shown
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.event_kind == EV_CONTENT ||
                     out_beat_o.event_kind == EV_FIELD ||
                     out_beat_o.event_kind == EV_ROW))
    else $error("bad event kind");

  // Field and row ends carry no character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.event_kind != EV_CONTENT |-> out_beat_o.out_char == 8'h00)
    else $error("non-content event carries a character");

  // Header events report row zero
  a_hdr_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.is_header |-> out_beat_o.row == 16'h0000)
    else $error("header event with nonzero row");

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (.*);

`default_nettype wire

// ===== test/csv_field_tokenizer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for csv_field_tokenizer_unit: quoting cases, column saturation
// and random CSV-like text, with random gaps on the text side and stalls on the event side.
// Depends on cft_pkg and the tokenizer RTL.

module csv_field_tokenizer_unit_tb;
  import cft_pkg::*;

  localparam int         WATCHDOG_LIMIT = 1000;
  localparam logic [7:0]  COL_MAX        = 8'd255;     // MAX_COLS - 1
  localparam logic [15:0] ROW_MAX        = 16'hFFFF;   // 2^ROW_BITS - 1

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  // Text bytes waiting for the driver, and events the tokenizer owes us.
  in_beat_t  text_queue[$];
  out_beat_t events_due[$];

  // Our own copy of the parse state and the header register.
  logic        hdr_en     = 1'b0;
  logic        quoted     = 1'b0;
  logic        quote_held = 1'b0;
  logic [7:0]  col_cnt    = '0;
  logic [15:0] row_cnt    = '0;
  logic        hdr_done   = 1'b0;
  logic        ovf_seen   = 1'b0;

  int        gap_max        = 13;
  int        stall_max      = 13;
  int        drv_wait       = 0;
  int        mon_wait       = 0;
  int        mismatch_count = 0;
  int        event_idx      = 0;
  int        quiet_cycles   = 0;
  logic      took;
  out_beat_t due_ev;

  csv_field_tokenizer_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    if (mismatch_count < 100) begin
      $display("event %0d: %s", event_idx, msg);
    end
    mismatch_count++;
  endtask

  // Event as the tokenizer should tag it right now: column before it advances,
  // row forced to 0 on the header row, overflow after this byte's update.
  function automatic out_beat_t make_event(input logic [1:0] kind, input logic [7:0] ch,
                                           input logic hdr);
    out_beat_t ev;
    ev.event_kind = kind;
    ev.out_char   = ch;
    ev.column     = col_cnt;
    ev.row        = hdr ? 16'd0 : row_cnt;
    ev.is_header  = hdr;
    ev.overflow   = ovf_seen;
    return ev;
  endfunction

  // Queue one expected event at the tail.
  function automatic void due_add(input out_beat_t ev);
    events_due.insert(events_due.size(), ev);
  endfunction

  // Advance the parse state by one text byte and queue the event it causes.
  task automatic tokenize_byte(input in_beat_t b);
    logic hdr;
    logic done;
    hdr  = hdr_en && !hdr_done;
    done = 1'b0;
    // A quote seen while quoted is resolved by the byte after it.
    if (quote_held) begin
      quote_held = 1'b0;
      if (b.text_byte == CH_QUOTE) begin
        due_add(make_event(EV_CONTENT, b.text_byte, hdr));
        done = 1'b1;
      end else begin
        quoted = 1'b0;
      end
    end
    if (!done) begin
      if (b.text_byte == CH_QUOTE) begin
        if (quoted) quote_held = 1'b1;
        else quoted = 1'b1;
      end else if (quoted) begin
        due_add(make_event(EV_CONTENT, b.text_byte, hdr));
      end else if (b.text_byte == CH_COMMA) begin
        if (col_cnt == COL_MAX) ovf_seen = 1'b1;
        due_add(make_event(EV_FIELD, 8'h00, hdr));
        if (col_cnt != COL_MAX) col_cnt = col_cnt + 8'd1;
      end else if (b.text_byte == CH_LF) begin
        // header row end never touches the row counter
        if (!hdr && row_cnt == ROW_MAX) ovf_seen = 1'b1;
        due_add(make_event(EV_ROW, 8'h00, hdr));
        col_cnt = '0;
        if (hdr) hdr_done = 1'b1;
        else if (row_cnt != ROW_MAX) row_cnt = row_cnt + 16'd1;
      end else if (b.text_byte != CH_CR) begin
        due_add(make_event(EV_CONTENT, b.text_byte, hdr));
      end
    end
    // end of text: everything but the register goes back to reset
    if (b.end_of_text) begin
      quoted     = 1'b0;
      quote_held = 1'b0;
      col_cnt    = '0;
      row_cnt    = '0;
      hdr_done   = 1'b0;
      ovf_seen   = 1'b0;
    end
  endtask

  // Driver: one beat at a time, a random gap drawn after each accepted item.
  always @(posedge clk) begin
    if (rst_n) begin
      took = in_valid && !in_stall;
      if (took) tokenize_byte(in_beat);
      if (took || !in_valid) begin
        if (drv_wait != 0) begin
          drv_wait--;
          in_valid <= 1'b0;
        end else if (text_queue.size() != 0) begin
          in_beat  <= text_queue.pop_front();
          in_valid <= 1'b1;
          drv_wait = $urandom_range(0, gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted event with the oldest one due, then stall
  // for a freshly drawn number of cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (events_due.size() == 0) begin
          report($sformatf("unexpected event, kind %0d char %02h", out_beat.event_kind,
                           out_beat.out_char));
        end else begin
          due_ev = events_due.pop_front();
          if (out_beat.event_kind !== due_ev.event_kind)
            report($sformatf("event_kind got %0d want %0d", out_beat.event_kind,
                             due_ev.event_kind));
          if (out_beat.out_char !== due_ev.out_char)
            report($sformatf("out_char got %02h want %02h", out_beat.out_char,
                             due_ev.out_char));
          if (out_beat.column !== due_ev.column)
            report($sformatf("column got %0d want %0d", out_beat.column, due_ev.column));
          if (out_beat.row !== due_ev.row)
            report($sformatf("row got %0d want %0d", out_beat.row, due_ev.row));
          if (out_beat.is_header !== due_ev.is_header)
            report($sformatf("is_header got %0b want %0b", out_beat.is_header,
                             due_ev.is_header));
          if (out_beat.overflow !== due_ev.overflow)
            report($sformatf("overflow got %0b want %0b", out_beat.overflow,
                             due_ev.overflow));
        end
        event_idx++;
        mon_wait = $urandom_range(0, stall_max);
      end else if (mon_wait != 0) begin
        mon_wait--;
      end
      out_stall <= (mon_wait != 0);
    end
  end

  // Watchdog: too long without a beat on either side means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("csv_field_tokenizer_unit_tb: errors");
        $finish;
      end
    end
  end

  function automatic void push_text(input logic [7:0] ch, input logic eot);
    text_queue.insert(text_queue.size(), in_beat_t'{text_byte: ch, end_of_text: eot});
  endfunction

  // Let all text drain and every due event arrive, then wait so that a byte
  // that causes no event can settle.
  task automatic wait_idle();
    while (text_queue.size() != 0 || in_valid || events_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_hdr(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hdr_en = v;
    @(negedge clk);
  endtask

  // Mostly well-formed CSV: plain fields, commas, CRLF/LF row ends and quoted
  // fields with embedded separators and doubled quotes; the rest is noise.
  task automatic fill_random(input int count);
    logic [7:0] seq[$];
    int sent;
    int r;
    int k;
    int j;
    sent = 0;
    while (sent < count) begin
      seq = {};
      r = $urandom_range(0, 99);
      if (r < 40) begin
        seq = {seq, 8'($urandom_range(8'h30, 8'h7A))};
      end else if (r < 55) begin
        seq = {seq, CH_COMMA};
      end else if (r < 65) begin
        if ($urandom_range(0, 1)) seq = {seq, CH_CR};
        seq = {seq, CH_LF};
      end else if (r < 82) begin
        seq = {seq, CH_QUOTE};
        k = $urandom_range(0, 6);
        for (j = 0; j < k; j++) begin
          case ($urandom_range(0, 5))
            0: begin
              seq = {seq, CH_QUOTE, CH_QUOTE};
            end
            1: seq = {seq, CH_COMMA};
            2: seq = {seq, CH_LF};
            3: seq = {seq, CH_CR};
            default: seq = {seq, 8'($urandom_range(0, 255))};
          endcase
        end
        seq = {seq, CH_QUOTE};
      end else if (r < 94) begin
        seq = {seq, 8'($urandom_range(0, 255))};
      end else begin
        seq = {seq, CH_QUOTE};
      end
      for (j = 0; j < seq.size(); j++) push_text(seq[j], $urandom_range(0, 149) == 0);
      sent += seq.size();
    end
  endtask

  initial begin
    int n;
    int batch;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: header row with quoting corners, then a data row, then the
    // end-of-text cases.
    write_hdr(1'b1);
    push_text("h", 1'b0);
    push_text(CH_COMMA, 1'b0);
    push_text(CH_QUOTE, 1'b0);     // enter quotes
    push_text("x", 1'b0);
    push_text(CH_COMMA, 1'b0);     // comma inside quotes is content
    push_text(CH_LF, 1'b0);        // so is a newline
    push_text(CH_QUOTE, 1'b0);     // held...
    push_text(CH_QUOTE, 1'b0);     // ...doubled: one literal quote
    push_text(CH_QUOTE, 1'b0);     // held, then closed by the comma
    push_text(CH_COMMA, 1'b0);
    push_text(CH_CR, 1'b0);        // dropped
    push_text(CH_LF, 1'b0);        // header row ends
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(CH_QUOTE, 1'b0);
    push_text(CH_CR, 1'b0);        // quoted CR is content
    push_text(CH_QUOTE, 1'b0);
    push_text(CH_LF, 1'b0);        // leaves quotes, data row 0 ends
    push_text("z", 1'b0);
    push_text(CH_QUOTE, 1'b0);
    push_text(CH_QUOTE, 1'b1);     // pending quote dropped at end of text
    push_text("a", 1'b1);
    wait_idle();

    // Column counter runs into its ceiling.
    write_hdr(1'b0);
    for (n = 0; n < 258; n++) push_text(CH_COMMA, 1'b0);
    push_text("x", 1'b0);
    push_text(CH_LF, 1'b1);
    wait_idle();

    // Random text in batches; the header register changes between batches
    // without ending the text, and the sender pauses until all events are in.
    for (batch = 0; batch < 6; batch++) begin
      gap_max   = (batch == 3) ? 0 : 13;
      stall_max = (batch == 3) ? 0 : 13;
      write_hdr(batch == 0 ? 1'b1 : 1'($urandom_range(0, 1)));
      fill_random(50);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && events_due.size() == 0) begin
      $display("csv_field_tokenizer_unit_tb: clean");
    end else begin
      $display("csv_field_tokenizer_unit_tb: errors");
    end
    $finish;
  end

endmodule
